### rtl/hpep_pkg.sv
// hpep_pkg: shared constants, payload structs and controller/datapath
// command and status groups for the host/port endpoint parser
// no dependencies
`default_nettype none

package hpep_pkg;

  // buffer sizing
  localparam int MAX_CHARS = 64;
  localparam int MAX_HOST  = 63;
  localparam int POS_W     = $clog2(MAX_CHARS);
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int CMP_W     = 10;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // character codes
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // port limit
  localparam logic [19:0] PORT_MAX = 20'd65535;

  // output item kinds
  localparam logic KIND_HOST  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // parse status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  host_byte;
    logic [15:0] port_number;
    logic        parse_status;
    logic        last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic rd_en;
    logic port_step;
    logic judge;
    logic emit_host;
    logic emit_final;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_fail;
    logic nondigit;
    logic port_last;
    logic port_bad;
    logic host_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/host_port_endpoint_parser.sv
// host_port_endpoint_parser: top level, joins the sequencer and the datapath
// depends on hpep_pkg, hpep_ctrl, hpep_dp (and through it hpep_ram)
//
//   channel | direction | beat                       | handshake
//   --------+-----------+----------------------------+---------------------
//   in      | input     | in_item_t: char, last mark | in_valid / in_ready
//   out     | output    | out_item_t: host or final  | out_valid / out_ready
//   cfg     | input     | host_capacity, 7 bits      | cfg_valid / cfg_ready
//
// loading stores the characters; then evaluation, a read and check per port digit, a port
// judgement, a read and emit per host byte, the final item; failures skip to the final item
// in_ready is low from the last character until the final item is registered
// reset is synchronous; the character store needs no clearing pass
// a stalled out_ready holds the walk at the next host byte or the final item
`default_nettype none

module host_port_endpoint_parser
  import hpep_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire in_item_t         in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      out_item_t        out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // register write always taken
  assign cfg_ready = 1'b1;

  hpep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_char),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpep_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/hpep_ram.sv
// hpep_ram: generic single write port, single read port RAM, registered read
// no dependencies
`default_nettype none

module hpep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/hpep_ctrl.sv
// hpep_ctrl: sequencer for load, evaluate, port walk, host emit and final item
// depends on hpep_pkg
`default_nettype none

module hpep_ctrl
  import hpep_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output      logic     in_ready,
  input  wire sts_t     sts,
  output      cmd_t     cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PCHK  = 3'd3;
  localparam logic [2:0] S_JUDGE = 3'd4;
  localparam logic [2:0] S_HRD   = 3'd5;
  localparam logic [2:0] S_HOUT  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_LOAD);

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.eval_fail ? S_FIN : S_PRD;
      end
      S_PRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        cmd.port_step = 1'b1;
        priority if (sts.nondigit) begin
          state_next = S_FIN;
        end else if (sts.port_last) begin
          state_next = S_JUDGE;
        end else begin
          state_next = S_PRD;
        end
      end
      S_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = sts.port_bad ? S_FIN : S_HRD;
      end
      S_HRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_HOUT;
      end
      S_HOUT: begin
        if (sts.out_free) begin
          cmd.emit_host = 1'b1;
          state_next    = sts.host_last ? S_FIN : S_HRD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hpep_dp.sv
// hpep_dp: character store, position trackers, port accumulator, output register
// depends on hpep_pkg, hpep_ram
`default_nettype none

module hpep_dp
  import hpep_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output      sts_t              sts,
  input  wire in_item_t          in_data,
  input  wire logic              cfg_valid,
  input  wire logic [CAP_W-1:0]  cfg_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      out_item_t         out_data
);

  // configuration
  logic [CAP_W-1:0] host_capacity;

  // run trackers
  logic [CNT_W-1:0] stored_count;
  logic             seen_nonspace;
  logic [POS_W-1:0] last_nonspace_pos;
  logic             close_valid;
  logic [POS_W-1:0] first_close_pos;
  logic             colon_valid;
  logic [POS_W-1:0] last_colon_pos;
  logic [1:0]       colon_tally;
  logic             too_long_flag;
  logic [7:0]       first_char;
  logic             close_then_colon;

  // evaluation registers
  logic             fail;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] port_end;
  logic [CNT_W-1:0] host_base;
  logic [CNT_W-1:0] host_left;
  logic [15:0]      port_val;
  logic             port_ovf;

  // ram
  logic             ram_we;
  logic [7:0]       ram_q;

  // incoming character classes
  logic [7:0]       c;
  logic             c_space;
  logic             c_keep;
  logic             c_room;
  logic [POS_W-1:0] pos;

  assign c       = in_data.char_byte;
  assign c_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_keep  = seen_nonspace || !c_space;
  assign c_room  = (stored_count < CNT_W'(MAX_CHARS));
  assign pos     = stored_count[POS_W-1:0];
  assign ram_we  = cmd.load && c_keep && c_room;

  hpep_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (c),
    .re    (cmd.rd_en),
    .raddr (idx[POS_W-1:0]),
    .rdata (ram_q)
  );

  // evaluation of the split points
  logic [CMP_W-1:0] len_e;
  logic [CMP_W-1:0] cl_e;
  logic [CMP_W-1:0] colon_e;
  logic [CMP_W-1:0] hs_e;
  logic [CMP_W-1:0] hl_e;
  logic [CMP_W-1:0] ps_e;
  logic             shape_bad;
  logic             eval_fail;

  always_comb begin
    len_e   = CMP_W'(last_nonspace_pos) + CMP_W'(1);
    cl_e    = CMP_W'(first_close_pos);
    colon_e = CMP_W'(last_colon_pos);
    if (first_char == CH_OPEN) begin
      shape_bad = !close_valid || (cl_e < CMP_W'(2)) || !close_then_colon;
      hs_e      = CMP_W'(1);
      hl_e      = cl_e - CMP_W'(1);
      ps_e      = cl_e + CMP_W'(2);
    end else begin
      shape_bad = !colon_valid || (colon_tally != 2'd1) || (last_colon_pos == '0);
      hs_e      = '0;
      hl_e      = colon_e;
      ps_e      = colon_e + CMP_W'(1);
    end
    eval_fail = too_long_flag || !seen_nonspace || shape_bad || (ps_e >= len_e)
             || (hl_e > CMP_W'(MAX_HOST)) || (hl_e >= CMP_W'(host_capacity));
  end

  // port digit step
  logic        d_digit;
  logic [19:0] acc_next;
  assign d_digit  = (ram_q >= CH_ZERO) && (ram_q <= CH_NINE);
  assign acc_next = {1'b0, port_val, 3'b000} + {3'b000, port_val, 1'b0}
                  + 20'(ram_q - CH_ZERO);

  // output slot
  logic out_free;
  assign out_free = !out_valid || out_ready;

  assign sts.eval_fail = eval_fail;
  assign sts.nondigit  = !d_digit;
  assign sts.port_last = (idx == port_end);
  assign sts.port_bad  = port_ovf || (port_val == '0);
  assign sts.host_last = (host_left == CNT_W'(1));
  assign sts.out_free  = out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      host_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      host_capacity <= cfg_data;
    end
  end

  // character trackers, cleared when the final item goes out
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_final) begin
      stored_count      <= '0;
      seen_nonspace     <= 1'b0;
      last_nonspace_pos <= '0;
      close_valid       <= 1'b0;
      first_close_pos   <= '0;
      colon_valid       <= 1'b0;
      last_colon_pos    <= '0;
      colon_tally       <= '0;
      too_long_flag     <= 1'b0;
      close_then_colon  <= 1'b0;
    end else if (cmd.load && c_keep) begin
      if (!c_room) begin
        too_long_flag <= 1'b1;
      end else begin
        stored_count <= stored_count + CNT_W'(1);
        if (!c_space) begin
          seen_nonspace     <= 1'b1;
          last_nonspace_pos <= pos;
        end
        if (c == CH_CLOSE && !close_valid) begin
          close_valid     <= 1'b1;
          first_close_pos <= pos;
        end
        if (c == CH_COLON) begin
          colon_valid    <= 1'b1;
          last_colon_pos <= pos;
          if (colon_tally != 2'd2) begin
            colon_tally <= colon_tally + 2'd1;
          end
          if (close_valid && (CNT_W'(pos) == CNT_W'(first_close_pos) + CNT_W'(1))) begin
            close_then_colon <= 1'b1;
          end
        end
      end
    end
  end

  // copy of the first kept character
  always_ff @(posedge clk) begin
    if (ram_we && (stored_count == '0)) begin
      first_char <= c;
    end
  end

  // evaluation, port walk and host walk
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_final) begin
      fail <= 1'b0;
    end else if (cmd.eval) begin
      fail <= eval_fail;
    end else if (cmd.port_step && !d_digit) begin
      fail <= 1'b1;
    end else if (cmd.judge && sts.port_bad) begin
      fail <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      idx        <= ps_e[CNT_W-1:0];
      port_end   <= len_e[CNT_W-1:0] - CNT_W'(1);
      host_base  <= hs_e[CNT_W-1:0];
      host_left  <= hl_e[CNT_W-1:0];
      port_val   <= '0;
      port_ovf   <= 1'b0;
    end else if (cmd.port_step) begin
      idx <= idx + CNT_W'(1);
      if (d_digit && !port_ovf) begin
        if (acc_next > PORT_MAX) begin
          port_ovf <= 1'b1;
        end else begin
          port_val <= acc_next[15:0];
        end
      end
    end else if (cmd.judge) begin
      idx <= host_base;
    end else if (cmd.emit_host) begin
      idx       <= idx + CNT_W'(1);
      host_left <= host_left - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_host || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_host) begin
      out_data.item_kind    <= KIND_HOST;
      out_data.host_byte    <= ram_q;
      out_data.port_number  <= '0;
      out_data.parse_status <= STAT_OK;
      out_data.last_result  <= 1'b0;
    end else if (cmd.emit_final) begin
      out_data.item_kind    <= KIND_FINAL;
      out_data.host_byte    <= '0;
      out_data.port_number  <= fail ? 16'd0 : port_val;
      out_data.parse_status <= fail ? STAT_FAIL : STAT_OK;
      out_data.last_result  <= 1'b1;
    end
  end

endmodule

`default_nettype wire
